// ===== sv/sss_pkg.sv =====
package sss_pkg;

	localparam int NUM_SUBSTACKS_DEF = 8;
	localparam int CAP_MAX_DEF       = 16;
	localparam int DATA_WIDTH_DEF    = 32;

	localparam logic [4:0] SUB_CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		ACT_PUSH   = 2'd0,
		ACT_POP    = 2'd1,
		ACT_POP_AT = 2'd2,
		ACT_NONE   = 2'd3
	} sss_action_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NO_STACK = 2'd2,
		ST_FULL     = 2'd3
	} sss_status_t;

	typedef struct packed {
		sss_status_t status;
		logic        pop;
		logic [2:0]  touched;
		logic [3:0]  in_use;
	} sss_res_t;

endpackage

// ===== sv/sss_mem.sv =====
module sss_mem #(
	parameter int DEPTH  = 128,
	parameter int ADDR_W = 7,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/sss_ctrl.sv =====
module sss_ctrl #(
	parameter int NUM_SUBSTACKS = sss_pkg::NUM_SUBSTACKS_DEF,
	parameter int CAP_MAX       = sss_pkg::CAP_MAX_DEF,
	parameter int DATA_WIDTH    = sss_pkg::DATA_WIDTH_DEF,
	parameter int ADDR_W        = $clog2(NUM_SUBSTACKS * CAP_MAX)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  sss_pkg::sss_action_t    action,
	input  logic [DATA_WIDTH-1:0]   value,
	input  logic [2:0]              stack_index,
	input  logic [4:0]              sub_capacity,
	output sss_pkg::sss_res_t       res,
	output logic                    mem_we,
	output logic                    mem_re,
	output logic [ADDR_W-1:0]       mem_addr,
	output logic [DATA_WIDTH-1:0]   mem_wdata
);

	localparam int LG_W   = $clog2(NUM_SUBSTACKS);
	localparam int CNT_W  = $clog2(NUM_SUBSTACKS + 1);
	localparam int FILL_W = $clog2(CAP_MAX + 1);
	localparam int POS_W  = (CAP_MAX > 1) ? $clog2(CAP_MAX) : 1;
	localparam int CW     = (FILL_W > 5) ? FILL_W : 5;
	localparam int XW     = (CNT_W > 3) ? CNT_W : 3;

	logic [FILL_W-1:0] fill_q [NUM_SUBSTACKS];
	logic [LG_W-1:0]   map_q  [NUM_SUBSTACKS];
	logic [CNT_W-1:0]  count_q;

	logic [FILL_W-1:0] fill_n [NUM_SUBSTACKS];
	logic [LG_W-1:0]   map_n  [NUM_SUBSTACKS];
	logic [CNT_W-1:0]  count_n;

	logic [CW-1:0]     cap_eff;
	logic [CNT_W-1:0]  cnt_m1;
	logic [LG_W-1:0]   last_lg;
	logic [LG_W-1:0]   last_phys;
	logic              last_full;
	logic              open_new;
	logic              do_pop;
	logic [LG_W-1:0]   pop_lg;
	logic [LG_W-1:0]   pop_phys;
	logic [FILL_W-1:0] pop_fill;
	logic [LG_W-1:0]   tgt_phys;
	logic [POS_W-1:0]  tgt_pos;
	logic [LG_W-1:0]   touched_lg;
	sss_pkg::sss_status_t st;

	always_comb begin
		if (sub_capacity == 5'd0) begin
			cap_eff = CW'(1);
		end else if (CW'(sub_capacity) > CW'(CAP_MAX)) begin
			cap_eff = CW'(CAP_MAX);
		end else begin
			cap_eff = CW'(sub_capacity);
		end
	end

	assign cnt_m1    = count_q - CNT_W'(1);
	assign last_lg   = cnt_m1[LG_W-1:0];
	assign last_phys = map_q[last_lg];
	assign last_full = CW'(fill_q[last_phys]) >= cap_eff;
	assign pop_phys  = map_q[pop_lg];
	assign pop_fill  = fill_q[pop_phys] - FILL_W'(1);

	always_comb begin
		fill_n     = fill_q;
		map_n      = map_q;
		count_n    = count_q;
		st         = sss_pkg::ST_OK;
		do_pop     = 1'b0;
		pop_lg     = '0;
		tgt_phys   = '0;
		tgt_pos    = '0;
		touched_lg = '0;
		open_new   = (count_q == '0) || last_full;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		case (action)
			sss_pkg::ACT_PUSH: begin
				if (open_new && (count_q == CNT_W'(NUM_SUBSTACKS))) begin
					st = sss_pkg::ST_FULL;
				end else if (open_new) begin
					tgt_phys         = map_q[count_q[LG_W-1:0]];
					tgt_pos          = '0;
					fill_n[tgt_phys] = FILL_W'(1);
					count_n          = count_q + CNT_W'(1);
					touched_lg       = count_q[LG_W-1:0];
					mem_we           = 1'b1;
				end else begin
					tgt_phys         = last_phys;
					tgt_pos          = fill_q[last_phys][POS_W-1:0];
					fill_n[tgt_phys] = fill_q[last_phys] + FILL_W'(1);
					touched_lg       = last_lg;
					mem_we           = 1'b1;
				end
			end
			sss_pkg::ACT_POP: begin
				if (count_q == '0) begin
					st = sss_pkg::ST_EMPTY;
				end else begin
					pop_lg = last_lg;
					do_pop = 1'b1;
				end
			end
			sss_pkg::ACT_POP_AT: begin
				if (XW'(stack_index) >= XW'(count_q)) begin
					st = sss_pkg::ST_NO_STACK;
				end else begin
					pop_lg = LG_W'(stack_index);
					do_pop = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (do_pop) begin
			touched_lg       = pop_lg;
			tgt_phys         = pop_phys;
			tgt_pos          = pop_fill[POS_W-1:0];
			fill_n[pop_phys] = pop_fill;
			mem_re           = 1'b1;
			if (pop_fill == '0) begin
				// close the gap left by the emptied substack
				for (int i = 0; i < NUM_SUBSTACKS - 1; i++) begin
					if ((LG_W'(i) >= pop_lg) && (CNT_W'(i + 1) < count_q)) begin
						map_n[i] = map_q[i + 1];
					end
				end
				map_n[last_lg] = pop_phys;
				count_n        = cnt_m1;
			end
		end
	end

	assign mem_addr  = ADDR_W'(tgt_phys) * ADDR_W'(CAP_MAX) + ADDR_W'(tgt_pos);
	assign mem_wdata = value;

	assign res.status  = st;
	assign res.pop     = do_pop;
	assign res.touched = 3'(touched_lg);
	assign res.in_use  = 4'(count_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SUBSTACKS; i++) begin
				fill_q[i] <= '0;
				map_q[i]  <= LG_W'(i);
			end
			count_q <= '0;
		end else if (accept) begin
			fill_q  <= fill_n;
			map_q   <= map_n;
			count_q <= count_n;
		end
	end

endmodule

// ===== sv/segmented_stack_set.sv =====
// channel  | handshake            | beat
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | action, value, stack_index
// out      | out_valid / out_ready| status, popped_value, touched_stack, stacks_in_use
// cfg      | cfg_we               | cfg_wdata (sub_capacity)
//
// each beat: the accepting edge updates fill counts, map and the entry memory write
// or read; the result register is loaded from the entry memory's registered read
// port when the beat advances, which a stalled out channel delays
// in_ready is low from each accepted beat until it moves to the result register
// reset is asynchronous and takes effect at once; no memory clearing pass
// a stalled out channel holds the in channel after one further beat
module segmented_stack_set #(
	parameter int NUM_SUBSTACKS = sss_pkg::NUM_SUBSTACKS_DEF,
	parameter int CAP_MAX       = sss_pkg::CAP_MAX_DEF,
	parameter int DATA_WIDTH    = sss_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   action,
	input  logic signed [DATA_WIDTH-1:0] value,
	input  logic [2:0]                   stack_index,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   status,
	output logic signed [DATA_WIDTH-1:0] popped_value,
	output logic [2:0]                   touched_stack,
	output logic [3:0]                   stacks_in_use,
	input  logic                         cfg_we,
	input  logic [4:0]                   cfg_wdata
);

	localparam int DEPTH  = NUM_SUBSTACKS * CAP_MAX;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [4:0]              sub_capacity_q;
	logic                    accept;
	sss_pkg::sss_res_t       res;
	logic                    mem_we;
	logic                    mem_re;
	logic [ADDR_W-1:0]       mem_addr;
	logic [DATA_WIDTH-1:0]   mem_wdata;
	logic [DATA_WIDTH-1:0]   mem_rdata;
	logic                    valid_s1;
	sss_pkg::sss_res_t       res_s1;
	logic                    out_valid_q;
	sss_pkg::sss_res_t       res_q;
	logic [DATA_WIDTH-1:0]   popped_q;
	logic                    advance;

	assign in_ready = !valid_s1;
	assign accept   = in_valid && in_ready;
	assign advance  = valid_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_capacity_q <= sss_pkg::SUB_CAP_RESET;
		end else if (cfg_we) begin
			sub_capacity_q <= cfg_wdata;
		end
	end

	sss_ctrl #(
		.NUM_SUBSTACKS(NUM_SUBSTACKS),
		.CAP_MAX      (CAP_MAX),
		.DATA_WIDTH   (DATA_WIDTH),
		.ADDR_W       (ADDR_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (sss_pkg::sss_action_t'(action)),
		.value       (value),
		.stack_index (stack_index),
		.sub_capacity(sub_capacity_q),
		.res         (res),
		.mem_we      (mem_we),
		.mem_re      (mem_re),
		.mem_addr    (mem_addr),
		.mem_wdata   (mem_wdata)
	);

	sss_mem #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W),
		.DATA_W(DATA_WIDTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we && accept),
		.re   (mem_re && accept),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q    <= res_s1;
			popped_q <= res_s1.pop ? mem_rdata : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = res_q.status;
	assign popped_value  = popped_q;
	assign touched_stack = res_q.touched;
	assign stacks_in_use = res_q.in_use;

endmodule

// ===== sv/sss_chk.sv =====
module sss_chk #(
	parameter int NUM_SUBSTACKS = sss_pkg::NUM_SUBSTACKS_DEF,
	parameter int DATA_WIDTH    = sss_pkg::DATA_WIDTH_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [1:0]            status,
	input logic [DATA_WIDTH-1:0] popped_value,
	input logic [2:0]            touched_stack,
	input logic [3:0]            stacks_in_use
);

	// one beat at a time between acceptance and the result register
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on the cycle after a beat");

	a_fail_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != sss_pkg::ST_OK) |-> (popped_value == '0) && (touched_stack == '0))
		else $error("failed beat carries value or substack");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sss_pkg::ST_FULL) |-> stacks_in_use == 4'(NUM_SUBSTACKS))
		else $error("full status without every substack in use");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == sss_pkg::ST_EMPTY) |-> stacks_in_use == 4'd0)
		else $error("empty status with substacks in use");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(popped_value))
		else $error("result changed while stalled");

endmodule

bind segmented_stack_set sss_chk #(
	.NUM_SUBSTACKS(NUM_SUBSTACKS),
	.DATA_WIDTH   (DATA_WIDTH)
) u_sss_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.popped_value (popped_value),
	.touched_stack(touched_stack),
	.stacks_in_use(stacks_in_use)
);

// ===== tb/sv/stack_set_checker.sv =====
module stack_set_checker
	import sss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  action,
	input  logic [31:0] value,
	input  logic [2:0]  stack_index,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [31:0] popped_value,
	input  logic [2:0]  touched_stack,
	input  logic [3:0]  stacks_in_use,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	output int          errors,
	output int          pending,
	output int          checked,
	output int          n_ok,
	output int          n_empty,
	output int          n_missing,
	output int          n_full
);

	localparam int NSUB = NUM_SUBSTACKS_DEF;
	localparam int CAPM = CAP_MAX_DEF;

	typedef struct packed {
		sss_status_t status;
		logic [31:0] popped;
		logic [2:0]  touched;
		logic [3:0]  in_use;
	} op_result_t;

	logic [31:0] entries [NSUB][CAPM];
	logic [4:0]  fill [NSUB];
	logic [2:0]  lmap [NSUB];
	logic [3:0]  n_stacks;
	logic [4:0]  cap_reg;

	op_result_t awaited_results[$];
	op_result_t want;
	op_result_t got;

	function automatic logic [4:0] capacity_limit();
		if (cap_reg == 0)
			return 5'd1;
		if (cap_reg > CAPM)
			return 5'(CAPM);
		return cap_reg;
	endfunction

	// remove the top entry of logical substack lg, dropping the substack once empty
	function automatic logic [31:0] take_top(input logic [2:0] lg);
		logic [2:0]  ph;
		logic [4:0]  f;
		logic [31:0] v;
		int          i;
		ph = lmap[lg];
		f  = fill[ph];
		v  = '0;
		if (f > CAPM)
			f = 5'(CAPM);
		if (f > 0) begin
			f = f - 5'd1;
			v = entries[ph][f[3:0]];
		end
		fill[ph] = f;
		if (f == 0) begin
			for (i = lg; i + 1 < n_stacks; i++)
				lmap[i] = lmap[i + 1];
			lmap[3'(n_stacks - 4'd1)] = ph;
			n_stacks = n_stacks - 4'd1;
		end
		return v;
	endfunction

	function automatic op_result_t stack_op_outcome(input logic [1:0] act_bits,
		input logic [31:0] val, input logic [2:0] idx);
		op_result_t  r;
		sss_action_t act;
		logic [4:0]  c;
		logic [2:0]  ph;
		logic [4:0]  f;
		bit          open_next;
		act       = sss_action_t'(act_bits);
		r.status  = ST_OK;
		r.popped  = '0;
		r.touched = '0;
		case (act)
			ACT_PUSH: begin
				c = capacity_limit();
				open_next = (n_stacks == 0) || (fill[lmap[3'(n_stacks - 4'd1)]] >= c);
				if (open_next && n_stacks >= NSUB) begin
					r.status = ST_FULL;
				end else begin
					if (open_next) begin
						ph = lmap[n_stacks[2:0]];
						fill[ph] = '0;
						n_stacks = n_stacks + 4'd1;
					end
					r.touched = 3'(n_stacks - 4'd1);
					ph = lmap[r.touched];
					f  = fill[ph];
					if (f < CAPM) begin
						entries[ph][f[3:0]] = val;
						fill[ph] = f + 5'd1;
					end
				end
			end
			ACT_POP: begin
				if (n_stacks == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.touched = 3'(n_stacks - 4'd1);
					r.popped  = take_top(r.touched);
				end
			end
			ACT_POP_AT: begin
				if (idx >= n_stacks) begin
					r.status = ST_NO_STACK;
				end else begin
					r.touched = idx;
					r.popped  = take_top(idx);
				end
			end
			default: ;
		endcase
		r.in_use = n_stacks;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NSUB; p++) begin
				fill[p] = '0;
				lmap[p] = 3'(p);
				for (int e = 0; e < CAPM; e++)
					entries[p][e] = '0;
			end
			n_stacks = '0;
			cap_reg  = SUB_CAP_RESET;
			awaited_results.delete();
			errors    = 0;
			pending   = 0;
			checked   = 0;
			n_ok      = 0;
			n_empty   = 0;
			n_missing = 0;
			n_full    = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{sss_status_t'(status), popped_value, touched_stack, stacks_in_use};
				if (awaited_results.size() == 0) begin
					if (errors < 10)
						$display("unexpected beat: st %0d val %h stk %0d use %0d",
							status, popped_value, touched_stack, stacks_in_use);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					checked++;
					if (got.status !== want.status || got.popped !== want.popped ||
						got.touched !== want.touched || got.in_use !== want.in_use) begin
						if (errors < 10) begin
							$display("result %0d: expected st %0d val %h stk %0d use %0d",
								checked, want.status, want.popped, want.touched,
								want.in_use);
							$display("  actual st %0d val %h stk %0d use %0d",
								status, popped_value, touched_stack, stacks_in_use);
						end
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				want = stack_op_outcome(action, value, stack_index);
				case (want.status)
					ST_OK:       n_ok++;
					ST_EMPTY:    n_empty++;
					ST_NO_STACK: n_missing++;
					default:     n_full++;
				endcase
				awaited_results.insert(awaited_results.size(), want);
			end
			if (cfg_we)
				cap_reg = cfg_wdata;
			pending = awaited_results.size();
		end
	end

endmodule

// ===== tb/sv/segmented_stack_set_tb.sv =====
module segmented_stack_set_tb;
	import sss_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 120;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  action;
	logic [31:0] value;
	logic [2:0]  stack_index;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [31:0] popped_value;
	logic [2:0]  touched_stack;
	logic [3:0]  stacks_in_use;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;

	int errors, pending, checked, n_ok, n_empty, n_missing, n_full;
	int n_sent;
	int n_settings;
	int idle_cycles;
	int holds_asked;
	int holds_done;
	bit tx_fast;
	bit rx_fast;

	always #5 clk = ~clk;

	segmented_stack_set i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.value         (value),
		.stack_index   (stack_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.popped_value  (popped_value),
		.touched_stack (touched_stack),
		.stacks_in_use (stacks_in_use),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	stack_set_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.value         (value),
		.stack_index   (stack_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.popped_value  (popped_value),
		.touched_stack (touched_stack),
		.stacks_in_use (stacks_in_use),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked),
		.n_ok          (n_ok),
		.n_empty       (n_empty),
		.n_missing     (n_missing),
		.n_full        (n_full)
	);

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// result side: random stalls, no stalls when rx_fast, long hold on request
	initial begin
		int n;
		out_ready  = 1'b0;
		holds_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (holds_done != holds_asked) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_done++;
			end
			n = rx_fast ? 0 : $urandom_range(0, 8);
			if (n != 0) begin
				out_ready = 1'b0;
				repeat (n) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_op(input sss_action_t a, input logic [31:0] v, input logic [2:0] idx);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		action      = a;
		value       = v;
		stack_index = idx;
		in_valid    = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		n_sent++;
	endtask

	task automatic set_capacity(input logic [4:0] c);
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wdata = c;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		n_settings++;
	endtask

	task automatic rand_op(input int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			send_op(ACT_NONE, $urandom, 3'($urandom));
		else if (r < push_pct)
			send_op(ACT_PUSH, $urandom, 3'($urandom));
		else if (r < push_pct + (100 - push_pct) / 2)
			send_op(ACT_POP, $urandom, 3'($urandom));
		else
			send_op(ACT_POP_AT, $urandom, 3'($urandom_range(0, 7)));
	endtask

	task automatic run_phase(input logic [4:0] cap, input int items, input int push_pct,
		input bit fast, input bit hold);
		set_capacity(cap);
		tx_fast = fast;
		rx_fast = fast;
		if (hold) begin
			tx_fast = 1'b1;
			holds_asked++;
		end
		for (int k = 0; k < items; k++)
			rand_op(push_pct);
		tx_fast = 1'b0;
		rx_fast = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		action      = ACT_PUSH;
		value       = '0;
		stack_index = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		n_sent      = 0;
		n_settings  = 0;
		holds_asked = 0;
		tx_fast     = 1'b0;
		rx_fast     = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty set, unused action, extreme values at reset capacity
		send_op(ACT_POP, 32'h0, 3'd0);
		send_op(ACT_POP_AT, 32'h0, 3'd0);
		send_op(ACT_POP_AT, 32'hffff_ffff, 3'd7);
		send_op(ACT_NONE, 32'hffff_ffff, 3'd7);
		send_op(ACT_PUSH, 32'h7fff_ffff, 3'd0);
		send_op(ACT_PUSH, 32'h8000_0000, 3'd7);
		send_op(ACT_PUSH, 32'h0000_0000, 3'd0);
		send_op(ACT_PUSH, 32'hffff_ffff, 3'd0);
		send_op(ACT_POP_AT, 32'h0, 3'd1);
		send_op(ACT_POP, 32'h0, 3'd0);
		send_op(ACT_POP_AT, 32'h0, 3'd0);

		// one entry per substack: fill all, remove from the middle, the front and past the end
		set_capacity(5'd1);
		for (int k = 0; k < 8; k++)
			send_op(ACT_PUSH, 32'h1000 + k, 3'd0);
		send_op(ACT_POP_AT, 32'h0, 3'd3);
		send_op(ACT_POP_AT, 32'h0, 3'd0);
		send_op(ACT_POP_AT, 32'h0, 3'd6);
		send_op(ACT_POP, 32'h0, 3'd0);
		send_op(ACT_PUSH, 32'h5a5a_a5a5, 3'd0);

		run_phase(5'd0, 100, 55, 1'b0, 1'b0);
		run_phase(5'd31, 220, 85, 1'b0, 1'b0);
		run_phase(5'd3, 120, 60, 1'b0, 1'b1);
		run_phase(5'd16, 120, 40, 1'b0, 1'b0);
		run_phase(5'd1, 100, 60, 1'b1, 1'b0);
		run_phase(5'd17, 80, 70, 1'b0, 1'b0);
		run_phase(5'd2, 60, 55, 1'b0, 1'b0);
		run_phase(5'($urandom_range(0, 31)), 60, 55, 1'b0, 1'b0);

		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);

		$display("%0d operations over %0d capacity settings, %0d results compared",
			n_sent, n_settings, checked);
		$display("outcomes: %0d ok, %0d empty pops, %0d missing substacks, %0d pushes when full",
			n_ok, n_empty, n_missing, n_full);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/sss_pkg.sv
sv/sss_mem.sv
sv/sss_ctrl.sv
sv/segmented_stack_set.sv
sv/sss_chk.sv
tb/sv/stack_set_checker.sv
tb/sv/segmented_stack_set_tb.sv
